// File: rtl/ptc_pkg.sv
// Package: shared types and constants for pressure/temperature compensation.
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int unsigned CFG_W   = 48;
  localparam int unsigned NUM_W   = 80;
  localparam int unsigned DVS_W   = 40;
  localparam int unsigned QBITS   = 37;
  localparam int unsigned QUO_W   = QBITS + 1;
  localparam logic [QBITS-1:0] Q_CLAMP = {1'b1, {(QBITS-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_TEMP_COEFFS,
    REG_PRESS_A,
    REG_PRESS_B,
    REG_PRESS_C
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } ptc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [24:0]        pressure_q8;
    logic               pressure_valid;
  } ptc_out_t;

  // Sideband carried through the divider next to the quotient.
  typedef struct packed {
    logic signed [15:0] temp;
    logic               dvalid;
  } ptc_side_t;

endpackage

// File: rtl/ptc_div.sv
// Module: pipelined restoring divider, one quotient bit per stage, saturated.
`timescale 1ns / 1ps
module ptc_div
  import ptc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic                    neg_i,
  input  logic [NUM_W-1:0]        mag_i,
  input  logic [DVS_W-1:0]        dvs_i,
  input  ptc_side_t               side_i,
  output logic                    vld_o,
  output logic signed [QUO_W-1:0] quo_o,
  output ptc_side_t               side_o
);

  logic [DVS_W-1:0] rem_q  [QBITS+1];
  logic [QBITS-1:0] q_q    [QBITS+1];
  logic [QBITS-1:0] lo_q   [QBITS];
  logic [DVS_W-1:0] d_q    [QBITS+1];
  logic             neg_q  [QBITS+1];
  logic             ovf_q  [QBITS+1];
  ptc_side_t        side_q [QBITS+1];
  logic [QBITS:0]   vld_q;

  logic [NUM_W-QBITS-1:0] hi;
  assign hi = mag_i[NUM_W-1:QBITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QBITS-1:0], vld_i};
    end
  end

  // Entry: quotient overflows its field when the high part reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= hi >= (NUM_W-QBITS)'(dvs_i);
      rem_q[0]  <= hi[DVS_W-1:0];
      lo_q[0]   <= mag_i[QBITS-1:0];
      q_q[0]    <= '0;
      d_q[0]    <= dvs_i;
      neg_q[0]  <= neg_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic [DVS_W:0] sh;
    logic           ge;
    logic [DVS_W:0] diff;
    assign sh   = {rem_q[k-1], lo_q[k-1][QBITS-1]};
    assign ge   = sh >= {1'b0, d_q[k-1]};
    assign diff = sh - {1'b0, d_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
        q_q[k]    <= {q_q[k-1][QBITS-2:0], ge};
        d_q[k]    <= d_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
    if (k < QBITS) begin : g_lo
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[k] <= {lo_q[k-1][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  logic [QBITS-1:0]        mq;
  logic signed [QUO_W-1:0] quo_d;
  logic signed [QUO_W-1:0] quo_q;
  ptc_side_t               so_q;
  logic                    vo_q;

  always_comb begin
    mq = (ovf_q[QBITS] || (q_q[QBITS] > Q_CLAMP)) ? Q_CLAMP : q_q[QBITS];
    quo_d = neg_q[QBITS] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vld_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
      so_q  <= side_q[QBITS];
    end
  end

  assign vld_o  = vo_q;
  assign quo_o  = quo_q;
  assign side_o = so_q;

endmodule

// File: rtl/pressure_temp_compensation.sv
// Top level: pipelined barometric pressure and temperature compensation.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   in_data_i  (ptc_in_t)
//  out       output     out_valid_o / out_stall_i out_data_o (ptc_out_t)
//  cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
//  One transaction enters per cycle while in_stall_o is low. The pipeline has
//  54 register stages: 11 in the front end, 39 in the divider (entry, 37
//  quotient bits, output) and 4 in the back end. The whole pipeline advances
//  together; it holds only when the output register is full and the consumer
//  stalls, so in_stall_o follows that. Reset clears valid bits and coefficient
//  registers; data carry no reset.
//
module pressure_temp_compensation
  import ptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ptc_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ptc_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  // Coefficient registers
  logic [CFG_W-1:0] tc_q, pa_q, pb_q, pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_TEMP_COEFFS: tc_q <= cfg_wdata_i;
        REG_PRESS_A:     pa_q <= cfg_wdata_i;
        REG_PRESS_B:     pb_q <= cfg_wdata_i;
        REG_PRESS_C:     pc_q <= cfg_wdata_i;
        default:         tc_q <= tc_q;
      endcase
    end
  end

  // Idle-only configuration changes are the user's job; coefficients feed stages.
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = tc_q[15:0];
  assign t2 = $signed(tc_q[31:16]);
  assign t3 = $signed(tc_q[47:32]);
  assign p1 = pa_q[15:0];
  assign p2 = $signed(pa_q[31:16]);
  assign p3 = $signed(pa_q[47:32]);
  assign p4 = $signed(pb_q[15:0]);
  assign p5 = $signed(pb_q[31:16]);
  assign p6 = $signed(pb_q[47:32]);
  assign p7 = $signed(pc_q[15:0]);
  assign p8 = $signed(pc_q[31:16]);
  assign p9 = $signed(pc_q[47:32]);

  // Global advance: move everything unless a finished result is stalled.
  logic     adv;
  ptc_out_t out_q;
  logic     out_vld_q;
  assign adv        = ~out_vld_q | ~out_stall_i;
  assign in_stall_o = ~adv;

  // Front valid chain, one bit per stage S1..S11
  logic [10:0] sv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (adv) begin
      sv_q <= {sv_q[9:0], in_valid_i};
    end
  end

  // S1: offsets against T1, pressure complement
  logic signed [17:0] ta_q;
  logic signed [16:0] td_q;
  logic [20:0]        pp_q;
  // S2: first products
  logic signed [33:0] ta2_q, dd_q;
  logic [20:0]        pp2_q;
  // S3
  logic signed [22:0] ah_q;
  logic signed [37:0] b0_q;
  logic [20:0]        pp3_q;
  // S4
  logic signed [23:0] tf_q;
  logic [20:0]        pp4_q;
  // S5
  logic signed [15:0] tmp5_q;
  logic signed [24:0] e_q;
  logic [20:0]        pp5_q;
  // S6
  logic signed [49:0] ee_q;
  logic signed [40:0] ep5_q, ep2_q;
  logic signed [15:0] tmp6_q;
  logic [20:0]        pp6_q;
  // S7
  logic signed [65:0] bb1_q, aa1_q;
  logic signed [40:0] ep5b_q, ep2b_q;
  logic signed [15:0] tmp7_q;
  logic [20:0]        pp7_q;
  // S8
  logic signed [65:0] b_q, a2_q;
  logic signed [15:0] tmp8_q;
  logic [20:0]        pp8_q;
  // S9
  logic signed [49:0] dv_q;
  logic signed [65:0] n0_q;
  logic signed [15:0] tmp9_q;
  // S10
  logic signed [NUM_W-1:0] num_q;
  logic                    dpos_q;
  logic [DVS_W-1:0]        dvs_q;
  logic signed [15:0]      tmp10_q;
  // S11
  logic [NUM_W-1:0] mag_q;
  logic             neg_q;
  logic [DVS_W-1:0] dvs11_q;
  ptc_side_t        side11_q;

  logic signed [33:0] ta2_d, dd_d;
  logic signed [37:0] b0_d;
  logic signed [26:0] t5;
  logic signed [18:0] th;
  logic signed [15:0] tsat;
  logic signed [65:0] x9;
  logic signed [82:0] dv9;

  always_comb begin
    ta2_d = ta_q * t2;
    dd_d  = td_q * td_q;
    b0_d  = $signed(dd_q[33:12]) * t3;
    t5    = (27'(tf_q) <<< 2) + 27'(tf_q) + 27'sd128;
    th    = $signed(t5[26:8]);
    if (th > 19'sd32767) begin
      tsat = 16'sh7fff;
    end else if (th < -19'sd32768) begin
      tsat = -16'sh8000;
    end else begin
      tsat = th[15:0];
    end
    x9  = 66'sd140737488355328 + a2_q;
    dv9 = x9 * $signed({1'b0, p1});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // S1
      ta_q  <= $signed({1'b0, in_data_i.raw_temperature[19:3]})
               - $signed({1'b0, t1, 1'b0});
      td_q  <= $signed({1'b0, in_data_i.raw_temperature[19:4]}) - $signed({1'b0, t1});
      pp_q  <= 21'd1048576 - {1'b0, in_data_i.raw_pressure};
      // S2
      ta2_q <= ta2_d;
      dd_q  <= dd_d;
      pp2_q <= pp_q;
      // S3
      ah_q  <= $signed(ta2_q[33:11]);
      b0_q  <= b0_d;
      pp3_q <= pp2_q;
      // S4: fine temperature
      tf_q  <= 24'(ah_q) + $signed(b0_q[37:14]);
      pp4_q <= pp3_q;
      // S5
      tmp5_q <= tsat;
      e_q    <= 25'(tf_q) - 25'sd128000;
      pp5_q  <= pp4_q;
      // S6
      ee_q   <= e_q * e_q;
      ep5_q  <= e_q * p5;
      ep2_q  <= e_q * p2;
      tmp6_q <= tmp5_q;
      pp6_q  <= pp5_q;
      // S7
      bb1_q  <= ee_q * p6;
      aa1_q  <= ee_q * p3;
      ep5b_q <= ep5_q;
      ep2b_q <= ep2_q;
      tmp7_q <= tmp6_q;
      pp7_q  <= pp6_q;
      // S8
      b_q    <= bb1_q + (66'(ep5b_q) <<< 17) + (66'(p4) <<< 35);
      a2_q   <= (aa1_q >>> 8) + (66'(ep2b_q) <<< 12);
      tmp8_q <= tmp7_q;
      pp8_q  <= pp7_q;
      // S9: divisor and numerator base
      dv_q   <= $signed(dv9[82:33]);
      n0_q   <= ($signed({45'b0, pp8_q}) <<< 31) - b_q;
      tmp9_q <= tmp8_q;
      // S10
      num_q   <= NUM_W'(n0_q) * 80'sd3125;
      dpos_q  <= dv_q > 50'sd0;
      dvs_q   <= dv_q[DVS_W-1:0];
      tmp10_q <= tmp9_q;
      // S11: split sign and magnitude for the divider
      neg_q    <= num_q[NUM_W-1];
      mag_q    <= num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
      dvs11_q  <= dvs_q;
      side11_q <= '{temp: tmp10_q, dvalid: dpos_q};
    end
  end

  // Divider
  logic                    dq_vld;
  logic signed [QUO_W-1:0] quo;
  ptc_side_t               dq_side;

  ptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sv_q[10]),
    .neg_i  (neg_q),
    .mag_i  (mag_q),
    .dvs_i  (dvs11_q),
    .side_i (side11_q),
    .vld_o  (dq_vld),
    .quo_o  (quo),
    .side_o (dq_side)
  );

  // Back end: second-order correction
  logic [2:0] pv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      pv_q      <= {pv_q[1:0], dq_vld};
      out_vld_q <= pv_q[2];
    end
  end

  logic signed [QUO_W-1:0] p1_q, p2_q;
  logic signed [49:0]      ps2_q;
  logic signed [53:0]      p8p_q, p8p2_q;
  logic signed [65:0]      a9_q;
  logic signed [41:0]      sum_q;
  ptc_side_t               sd1_q, sd2_q, sd3_q;
  logic signed [24:0]      ps;
  logic signed [33:0]      rr;
  logic [24:0]             pres;

  always_comb begin
    ps = $signed(quo[QUO_W-1:13]);
    rr = $signed(sum_q[41:8]) + (34'(p7) <<< 4);
    if (!sd3_q.dvalid || rr < 34'sd0) begin
      pres = '0;
    end else if (rr > 34'sd33554431) begin
      pres = '1;
    end else begin
      pres = rr[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // P1
      p1_q   <= quo;
      ps2_q  <= ps * ps;
      p8p_q  <= p8 * quo;
      sd1_q  <= dq_side;
      // P2
      p2_q   <= p1_q;
      a9_q   <= ps2_q * p9;
      p8p2_q <= p8p_q;
      sd2_q  <= sd1_q;
      // P3
      sum_q  <= 42'(p2_q) + 42'($signed(a9_q[65:25])) + 42'($signed(p8p2_q[53:19]));
      sd3_q  <= sd2_q;
      // P4: output register
      out_q  <= '{temperature_centi: sd3_q.temp, pressure_q8: pres,
                  pressure_valid: sd3_q.dvalid};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // An invalid divisor never yields a non-zero pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.pressure_valid |-> out_q.pressure_q8 == '0)
    else $error("pressure not cleared on invalid divisor");

  // An accepted transaction lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> sv_q[0])
    else $error("accepted transaction lost at entry");

  // A held pipeline keeps its mid-stage contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && sv_q[4] |=> sv_q[4] && $stable(e_q))
    else $error("stage contents changed while held");

  // Divider output is within the clamp range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_vld |-> (quo <= $signed({1'b0, Q_CLAMP})) && (quo >= -$signed({1'b0, Q_CLAMP})))
    else $error("quotient outside clamp range");

endmodule

// File: tb/sv/pressure_temp_compensation_tb.sv
// Testbench for the pressure/temperature compensation pipeline.
`timescale 1ns / 1ps
module pressure_temp_compensation_tb;
  import ptc_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    ptc_in_t data;
    int      gap;
  } pend_item_t;

  localparam int LATENCY   = 54;
  localparam int CYCLE_CAP = 1000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  ptc_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  ptc_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Shadow copy of the coefficient registers, indexed by register number.
  logic [CFG_W-1:0] coef_shadow [4];

  pend_item_t pend_q[$];
  ptc_out_t   reading_q[$];
  logic       took = 1'b0;
  int         wait_cnt = 0;
  int         stall_cnt = 0;
  bit         calm = 0;
  int         errors = 0;
  int         cycles = 0;

  always #5 clk = ~clk;

  pressure_temp_compensation dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Compensate one raw sample pair with the shadow coefficients.
  function automatic ptc_out_t compensate(ptc_in_t s);
    ptc_out_t r;
    wide_t adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    wide_t a, b, d, t_fine, temp, num, p, ps;
    longint div;
    adc_t = 0;
    adc_p = 0;
    adc_t[19:0] = s.raw_temperature;
    adc_p[19:0] = s.raw_pressure;
    t1 = 0;
    p1 = 0;
    t1[15:0] = coef_shadow[REG_TEMP_COEFFS][15:0];
    p1[15:0] = coef_shadow[REG_PRESS_A][15:0];
    t2 = wide_t'($signed(coef_shadow[REG_TEMP_COEFFS][31:16]));
    t3 = wide_t'($signed(coef_shadow[REG_TEMP_COEFFS][47:32]));
    p2 = wide_t'($signed(coef_shadow[REG_PRESS_A][31:16]));
    p3 = wide_t'($signed(coef_shadow[REG_PRESS_A][47:32]));
    p4 = wide_t'($signed(coef_shadow[REG_PRESS_B][15:0]));
    p5 = wide_t'($signed(coef_shadow[REG_PRESS_B][31:16]));
    p6 = wide_t'($signed(coef_shadow[REG_PRESS_B][47:32]));
    p7 = wide_t'($signed(coef_shadow[REG_PRESS_C][15:0]));
    p8 = wide_t'($signed(coef_shadow[REG_PRESS_C][31:16]));
    p9 = wide_t'($signed(coef_shadow[REG_PRESS_C][47:32]));

    // fine temperature: linear term plus squared term
    a = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    t_fine = a + b;
    temp = (t_fine * 5 + 128) >>> 8;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;
    r.temperature_centi = temp[15:0];
    r.pressure_q8 = '0;
    r.pressure_valid = 1'b0;

    a = t_fine - 128000;
    b = a * a * p6 + a * p5 * 131072 + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + a * p2 * 4096;
    div = longint'(((wide_t'(1) <<< 47) + a) * p1 >>> 33);
    if (div > 0) begin
      r.pressure_valid = 1'b1;
      num = (((1048576 - adc_p) <<< 31) - b) * 3125;
      p = num / wide_t'(div);
      // hold the quotient within +-2^36 ahead of the second-order terms
      if (p > (wide_t'(1) <<< 36)) p = wide_t'(1) <<< 36;
      if (p < -(wide_t'(1) <<< 36)) p = -(wide_t'(1) <<< 36);
      ps = p >>> 13;
      a = (p9 * ps * ps) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + p7 * 16;
      if (p < 0) p = 0;
      if (p > 33554431) p = 33554431;
      r.pressure_q8 = p[24:0];
    end
    return r;
  endfunction

  // Sample both channels on the rising edge.
  always @(posedge clk) begin
    ptc_out_t want;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end else begin
      took <= rst_n && in_valid && !in_stall;
      if (rst_n && in_valid && !in_stall) reading_q.push_back(compensate(in_data));
      if (rst_n && out_valid && !out_stall) begin
        stall_cnt = calm ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0);
        if (reading_q.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          want = reading_q.pop_front();
          if (out_data.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi: expected %0d, got %0d",
                   want.temperature_centi, out_data.temperature_centi);
            errors++;
          end
          if (out_data.pressure_q8 !== want.pressure_q8) begin
            $error("pressure_q8: expected %0d, got %0d",
                   want.pressure_q8, out_data.pressure_q8);
            errors++;
          end
          if (out_data.pressure_valid !== want.pressure_valid) begin
            $error("pressure_valid: expected %0b, got %0b",
                   want.pressure_valid, out_data.pressure_valid);
            errors++;
          end
        end
      end
    end
  end

  // Input driver: present the next pending transaction after its gap.
  always @(negedge clk) begin
    logic nv;
    nv = in_valid && !took;
    if (rst_n && !nv) begin
      if (pend_q.size() != 0) begin
        if (wait_cnt < pend_q[0].gap) begin
          wait_cnt++;
        end else begin
          in_data <= pend_q[0].data;
          void'(pend_q.pop_front());
          wait_cnt = 0;
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
  end

  // Output stall: hold for the drawn count, then release.
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      out_stall <= 1'b1;
      stall_cnt--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [CFG_W-1:0] pack3(logic [15:0] c0, logic [15:0] c1,
                                              logic [15:0] c2);
    return {c2, c1, c0};
  endfunction

  task automatic reg_write(reg_idx_e r, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    coef_shadow[r] = v;
  endtask

  task automatic load_coeffs(logic [CFG_W-1:0] t, logic [CFG_W-1:0] pa,
                             logic [CFG_W-1:0] pb, logic [CFG_W-1:0] pc);
    reg_write(REG_TEMP_COEFFS, t);
    reg_write(REG_PRESS_A, pa);
    reg_write(REG_PRESS_B, pb);
    reg_write(REG_PRESS_C, pc);
  endtask

  task automatic queue_sample(logic [19:0] rt, logic [19:0] rp);
    pend_item_t it;
    it.data.raw_temperature = rt;
    it.data.raw_pressure = rp;
    it.gap = calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0);
    pend_q.push_back(it);
  endtask

  // Mix full-range noise with readings around a plausible operating point.
  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1))
        queue_sample(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
      else
        queue_sample(20'($urandom_range(400000, 600000)),
                     20'($urandom_range(200000, 500000)));
    end
  endtask

  // Drain: wait for every pending result, then let the pipeline empty.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || reading_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] typ_t, typ_a, typ_b, typ_c;
    for (int i = 0; i < 4; i++) coef_shadow[i] = '0;
    typ_t = pack3(16'd27504, 16'd26435, -16'sd1000);
    typ_a = pack3(16'd36477, -16'sd10685, 16'd3024);
    typ_b = pack3(16'd2855, 16'd140, -16'sd7);
    typ_c = pack3(16'd15500, -16'sd14600, 16'd6000);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at reset: divisor is zero, pressure flagged invalid.
    queue_sample(20'h00000, 20'h00000);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_random(50);
    drain();

    // Typical calibration, directed corners first.
    load_coeffs(typ_t, typ_a, typ_b, typ_c);
    queue_sample(20'h00000, 20'h00000);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_sample(20'h00000, 20'hFFFFF);
    queue_sample(20'hFFFFF, 20'h00000);
    queue_sample(20'hAAAAA, 20'h55555);
    queue_sample(20'h55555, 20'hAAAAA);
    queue_sample(20'd519888, 20'd415148);
    queue_sample(20'd519888, 20'd100000);
    queue_sample(20'd519888, 20'd1000);
    queue_sample(20'd300000, 20'd600000);
    queue_sample(20'd700000, 20'd300000);
    queue_sample(20'd440064, 20'h80000);
    queue_random(150);
    drain();

    // Near-typical calibration, no idling on either side.
    calm = 1;
    load_coeffs(typ_t ^ $urandom_range(0, 255), typ_a ^ $urandom_range(0, 255),
                typ_b, typ_c);
    queue_random(150);
    drain();
    calm = 0;

    // All ones.
    load_coeffs({CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
    queue_sample(20'h00000, 20'h00000);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_random(150);
    drain();

    // Largest positive coefficients.
    load_coeffs(pack3(16'hFFFF, 16'h7FFF, 16'h7FFF), pack3(16'hFFFF, 16'h7FFF, 16'h7FFF),
                pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), pack3(16'h7FFF, 16'h7FFF, 16'h7FFF));
    queue_sample(20'h00000, 20'h00000);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_random(150);
    drain();

    // Most negative coefficients.
    load_coeffs(pack3(16'h0000, 16'h8000, 16'h8000), pack3(16'h0001, 16'h8000, 16'h8000),
                pack3(16'h8000, 16'h8000, 16'h8000), pack3(16'h8000, 16'h8000, 16'h8000));
    queue_sample(20'h00000, 20'h00000);
    queue_sample(20'hFFFFF, 20'hFFFFF);
    queue_random(150);
    drain();

    // Random calibrations: bounded near typical, then fully random.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0)
        load_coeffs(typ_t ^ CFG_W'({$urandom, $urandom}) & 48'h00FF_0FFF_0FFF,
                    typ_a ^ CFG_W'({$urandom, $urandom}) & 48'h00FF_03FF_0FFF,
                    typ_b ^ CFG_W'({$urandom, $urandom}) & 48'h0007_00FF_0FFF,
                    typ_c ^ CFG_W'({$urandom, $urandom}) & 48'h0FFF_0FFF_0FFF);
      else
        load_coeffs(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                    CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}));
      queue_random(150);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: pressure_temp_compensation.f
rtl/ptc_pkg.sv
rtl/ptc_div.sv
rtl/pressure_temp_compensation.sv
tb/sv/pressure_temp_compensation_tb.sv
